// ----- src/gsoc_pkg.sv -----
package gsoc_pkg;

   localparam int unsigned MAX_BATCH  = 64;
   localparam int unsigned CSUM_BYTES = 2;
   localparam int unsigned CSR_INDEX_WIDTH = 3;
   localparam int unsigned CSR_DATA_WIDTH  = 16;

   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_MAX_MESSAGE_BYTES    = 3'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_SEGMENTS_PER_MESSAGE = 3'd1;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_MESSAGES_PER_BATCH   = 3'd2;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_PARCEL_MODE          = 3'd3;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_HEADER_BYTES         = 3'd4;

   localparam logic ACTION_SEGMENT = 1'b0;
   localparam logic ACTION_IDLE    = 1'b1;

   localparam logic [23:0] BYTES_MAX = 24'hFF_FFFF;

   typedef struct packed {
      logic        action;
      logic [15:0] segment_length;
   } req_type;

   typedef struct packed {
      logic [6:0]  message_index;
      logic        opens_message;
      logic [6:0]  segment_position;
      logic [31:0] control_word;
      logic        closes_message;
      logic        flush_batch;
      logic [23:0] batch_wire_bytes;
   } rsp_type;

   typedef struct packed {
      logic [15:0] max_message_bytes;
      logic [6:0]  segments_per_message;
      logic [6:0]  messages_per_batch;
      logic        parcel_mode;
      logic [7:0]  header_bytes;
   } cfg_type;

   typedef struct packed {
      logic [15:0] first_length;
      logic [6:0]  open_segments;
      logic [16:0] message_bytes;
      logic [6:0]  batch_messages;
      logic [23:0] batch_bytes;
   } state_type;

endpackage

// ----- src/gsoc_step.sv -----
module gsoc_step (
   input  gsoc_pkg::cfg_type   cfg,
   input  gsoc_pkg::state_type state_cur,
   input  gsoc_pkg::req_type   req,
   output gsoc_pkg::rsp_type   rsp,
   output gsoc_pkg::state_type state_nxt
);

   logic [1:0]  csum;
   logic [6:0]  seg_limit;
   logic [6:0]  batch_limit;
   logic [16:0] seg_cost;
   logic [16:0] open_cost;
   logic [17:0] msg_try;
   logic        start;
   logic [16:0] add_bytes;
   logic [24:0] bb_sum;
   logic [23:0] bb_sat;
   logic [6:0]  new_open;
   logic [6:0]  new_bm;
   logic [15:0] first_new;
   logic        closes;
   logic        flush;

   always_comb begin
      csum      = cfg.parcel_mode ? 2'(gsoc_pkg::CSUM_BYTES) : 2'd0;
      seg_limit = (cfg.segments_per_message == 7'd0) ? 7'd1 : cfg.segments_per_message;
      if (cfg.messages_per_batch == 7'd0) begin
         batch_limit = 7'd1;
      end else if (cfg.messages_per_batch > 7'(gsoc_pkg::MAX_BATCH)) begin
         batch_limit = 7'(gsoc_pkg::MAX_BATCH);
      end else begin
         batch_limit = cfg.messages_per_batch;
      end

      seg_cost  = 17'(req.segment_length) + 17'(csum);
      open_cost = seg_cost + 17'(cfg.header_bytes);
      msg_try   = 18'(state_cur.message_bytes) + 18'(seg_cost);
      start     = (state_cur.open_segments == 7'd0)
                  || (req.segment_length > state_cur.first_length)
                  || (seg_limit <= 7'd1)
                  || (msg_try > 18'(cfg.max_message_bytes));

      add_bytes = start ? open_cost : seg_cost;
      bb_sum    = 25'(state_cur.batch_bytes) + 25'(add_bytes);
      bb_sat    = bb_sum[24] ? gsoc_pkg::BYTES_MAX : bb_sum[23:0];
      new_open  = start ? 7'd1 : state_cur.open_segments + 7'd1;
      new_bm    = start ? state_cur.batch_messages + 7'd1 : state_cur.batch_messages;
      first_new = start ? req.segment_length : state_cur.first_length;
      closes    = start ? (seg_limit <= 7'd1)
                        : ((req.segment_length < state_cur.first_length)
                           || (new_open >= seg_limit));
      flush     = (closes && (new_bm >= batch_limit))
                  || (new_bm >= 7'(gsoc_pkg::MAX_BATCH));

      rsp       = '0;
      state_nxt = state_cur;

      if (req.action == gsoc_pkg::ACTION_IDLE) begin
         if (state_cur.batch_messages != 7'd0) begin
            rsp.flush_batch      = 1'b1;
            rsp.batch_wire_bytes = state_cur.batch_bytes;
            state_nxt            = '0;
         end
      end else if (req.segment_length != 16'd0) begin
         rsp.message_index    = start ? state_cur.batch_messages
                                      : state_cur.batch_messages - 7'd1;
         rsp.opens_message    = start;
         rsp.segment_position = new_open;
         rsp.control_word     = cfg.parcel_mode ? {9'd0, new_open, first_new}
                                                : {16'd0, first_new};
         rsp.closes_message   = closes;
         if (flush) begin
            rsp.flush_batch      = 1'b1;
            rsp.batch_wire_bytes = bb_sat;
            state_nxt            = '0;
         end else begin
            state_nxt.first_length   = first_new;
            state_nxt.open_segments  = closes ? 7'd0 : new_open;
            state_nxt.message_bytes  = start ? open_cost : msg_try[16:0];
            state_nxt.batch_messages = new_bm;
            state_nxt.batch_bytes    = bb_sat;
         end
      end
   end

endmodule

// ----- src/gso_segment_coalescer_core.sv -----
// The input register passes its word to the result register when that is free.
// One word per cycle unless stalled; the input register refills while the result waits.
// A stalled result register holds its word and stalls the input only when both are full.
// Reset is synchronous and active high: it clears all counters and both valid flags,
// and returns every configuration register to its default value.
module gso_segment_coalescer_core (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_valid,
   output logic                                   req_stall,
   input  gsoc_pkg::req_type                      req_word,
   output logic                                   rsp_valid,
   input  logic                                   rsp_stall,
   output gsoc_pkg::rsp_type                      rsp_word,
   input  logic                                   csr_write_en,
   input  logic [gsoc_pkg::CSR_INDEX_WIDTH-1:0]   csr_index,
   input  logic [gsoc_pkg::CSR_DATA_WIDTH-1:0]    csr_wdata
);

   gsoc_pkg::cfg_type   cfg_ff, cfg_in;
   gsoc_pkg::state_type state_ff, state_in;
   gsoc_pkg::req_type   in_word_ff;
   gsoc_pkg::rsp_type   rsp_word_ff, rsp_word_in;
   logic                in_valid_ff, in_valid_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic                out_free;
   logic                load_out;
   logic                req_take;
   gsoc_pkg::rsp_type   step_rsp;
   gsoc_pkg::state_type step_state;

   gsoc_step u_step (
      .cfg       (cfg_ff),
      .state_cur (state_ff),
      .req       (in_word_ff),
      .rsp       (step_rsp),
      .state_nxt (step_state)
   );

   always_comb begin
      out_free     = !rsp_valid_ff || !rsp_stall;
      load_out     = in_valid_ff && out_free;
      req_stall    = in_valid_ff && !out_free;
      req_take     = req_valid && !req_stall;
      in_valid_in  = req_take || (in_valid_ff && !out_free);
      rsp_valid_in = load_out || (rsp_valid_ff && rsp_stall);
      rsp_word_in  = load_out ? step_rsp : rsp_word_ff;
      state_in     = load_out ? step_state : state_ff;

      cfg_in = cfg_ff;
      if (csr_write_en) begin
         case (csr_index)
            gsoc_pkg::CSR_MAX_MESSAGE_BYTES: begin
               cfg_in.max_message_bytes = csr_wdata;
            end
            gsoc_pkg::CSR_SEGMENTS_PER_MESSAGE: begin
               cfg_in.segments_per_message = csr_wdata[6:0];
            end
            gsoc_pkg::CSR_MESSAGES_PER_BATCH: begin
               cfg_in.messages_per_batch = csr_wdata[6:0];
            end
            gsoc_pkg::CSR_PARCEL_MODE: begin
               cfg_in.parcel_mode = csr_wdata[0];
            end
            gsoc_pkg::CSR_HEADER_BYTES: begin
               cfg_in.header_bytes = csr_wdata[7:0];
            end
            default: begin
               cfg_in = cfg_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.max_message_bytes    <= 16'd65535;
         cfg_ff.segments_per_message <= 7'd64;
         cfg_ff.messages_per_batch   <= 7'd16;
         cfg_ff.parcel_mode          <= 1'b1;
         cfg_ff.header_bytes         <= 8'd28;
         state_ff                    <= '0;
         in_valid_ff                 <= 1'b0;
         rsp_valid_ff                <= 1'b0;
      end else begin
         cfg_ff       <= cfg_in;
         state_ff     <= state_in;
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         in_word_ff <= req_word;
      end
      rsp_word_ff <= rsp_word_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_word_ff;

   a_flush_clears: assert property (@(posedge clock) disable iff (reset)
      (load_out && step_rsp.flush_batch)
      |=> (state_ff.batch_messages == 7'd0 && state_ff.open_segments == 7'd0
           && state_ff.batch_bytes == 24'd0))
      else $error("flush did not clear the batch counters");

   a_wire_only_on_flush: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_word_ff.flush_batch) |-> (rsp_word_ff.batch_wire_bytes == 24'd0))
      else $error("wire bytes reported without a flush");

   a_open_needs_batch: assert property (@(posedge clock) disable iff (reset)
      (state_ff.open_segments != 7'd0) |-> (state_ff.batch_messages != 7'd0))
      else $error("open message with an empty batch");

   a_batch_bound: assert property (@(posedge clock) disable iff (reset)
      state_ff.batch_messages < 7'(gsoc_pkg::MAX_BATCH))
      else $error("batch message count reached its limit without a flush");

endmodule
